// File: rtl/zph_pkg.sv
// ----------------------------------------------------------------------------
// Zobrist position hasher package
// Shared codes, table layout constants and index helpers for the hasher.
// ----------------------------------------------------------------------------
package zph_pkg;

  localparam int KEY_TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BITS_DEF        = 64;
  localparam int BOARD_SQUARES       = 64;

  // Width of every key index the block computes; the highest used entry is 780.
  localparam int KEY_INDEX_W = 10;
  localparam int NUM_KEYS    = 7;

  localparam logic [KEY_INDEX_W-1:0] CASTLE_BASE = KEY_INDEX_W'(2 * 6 * BOARD_SQUARES);
  localparam logic [KEY_INDEX_W-1:0] EP_BASE     = KEY_INDEX_W'(2 * 6 * BOARD_SQUARES + 4);
  localparam logic [KEY_INDEX_W-1:0] SIDE_INDEX  = KEY_INDEX_W'(2 * 6 * BOARD_SQUARES + 12);

  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_PIECE  = 3'd1,
    MODE_CASTLE = 3'd2,
    MODE_EP     = 3'd3,
    MODE_FINISH = 3'd4,
    MODE_MOVE   = 3'd5
  } mode_e;

  localparam logic [2:0] KIND_PAWN   = 3'd0;
  localparam logic [2:0] KIND_KNIGHT = 3'd1;
  localparam logic [2:0] KIND_BISHOP = 3'd2;
  localparam logic [2:0] KIND_ROOK   = 3'd3;
  localparam logic [2:0] KIND_QUEEN  = 3'd4;
  localparam logic [2:0] KIND_KING   = 3'd5;

  localparam logic RES_POSITION = 1'b0;
  localparam logic RES_MOVE     = 1'b1;

  // Lanes of the result, lowest first.
  localparam int KEY_FULL    = 0;
  localparam int KEY_PAWN    = 1;
  localparam int KEY_KPAWN   = 2;
  localparam int KEY_NPWHITE = 3;
  localparam int KEY_NPBLACK = 4;
  localparam int KEY_MINOR   = 5;
  localparam int KEY_MAJOR   = 6;

  // Decoded control of one item as it moves from address stage to key stage.
  typedef struct packed {
    mode_e      mode;
    logic       color;
    logic [2:0] kind;
    logic       use_a;
    logic       use_b;
    logic       use_c;
    logic       has_result;
  } item_ctrl_t;

  function automatic logic [KEY_INDEX_W-1:0] piece_index(logic col, logic [2:0] kind,
                                                         logic [5:0] sq);
    logic [KEY_INDEX_W-1:0] base;
    base = col ? KEY_INDEX_W'(6 * BOARD_SQUARES) : '0;
    return base + KEY_INDEX_W'({kind, sq});
  endfunction

endpackage

// File: rtl/zobrist_position_hasher.sv
// ----------------------------------------------------------------------------
// Zobrist position hasher
// Key table with piece, castle, en-passant and side keys, seven position
// accumulators and a move update path.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the mode, tdata the
// key table index, data word and board fields. Write requests load the key
// table, piece, castle and en-passant requests fold one key into the
// accumulators, a finish request returns all seven keys and clears them, and
// a move request returns a base key updated for one move.
// Results leave on the m_axis channel; tuser is the result kind.
// One request is taken every cycle unless the receiver stalls. A request's
// keys are read from the key table, then its result goes to the output register.
// The key table is held three times, one copy per read port, so a move
// request reads its origin, arrival and capture keys in the same cycle.
// A key written by one request is seen by the request right after it.
// Reset clears the accumulators and the pipeline; the key table keeps no
// reset and must be loaded before use. When the receiver stalls, the output
// register holds its result and requests that yield no result still go
// through; the next result-bearing request waits in the read stage and the
// input stops taking requests until the output register frees.
// ----------------------------------------------------------------------------
module zobrist_position_hasher #(
  parameter int KEY_TABLE_DEPTH = zph_pkg::KEY_TABLE_DEPTH_DEF,
  parameter int KEY_BITS        = zph_pkg::KEY_BITS_DEF,
  localparam int S_TDATA_W      = ((KEY_BITS + 37 + 7) / 8) * 8,
  localparam int M_TDATA_W      = ((KEY_BITS * zph_pkg::NUM_KEYS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // table_index, data_word, color, piece_kind, square, target_square,
  // promotion_kind, captured_kind, castle_side, ep_file, black_to_move
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // position_key, pawn_hash, king_pawn_hash, nonpawn_white_key,
  // nonpawn_black_key, minor_piece_hash, major_piece_hash
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic [0:0]           m_axis_tuser
);
  import zph_pkg::*;

  localparam int AW       = $clog2(KEY_TABLE_DEPTH);
  localparam int OFS_DATA = 10;
  localparam int OFS_COL  = OFS_DATA + KEY_BITS;
  localparam int OFS_KIND = OFS_COL + 1;
  localparam int OFS_SQ   = OFS_KIND + 3;
  localparam int OFS_TSQ  = OFS_SQ + 6;
  localparam int OFS_PRO  = OFS_TSQ + 6;
  localparam int OFS_CAP  = OFS_PRO + 3;
  localparam int OFS_SIDE = OFS_CAP + 3;
  localparam int OFS_FILE = OFS_SIDE + 1;
  localparam int OFS_BLK  = OFS_FILE + 3;

  // Request fields
  mode_e               in_mode;
  logic [9:0]          in_index;
  logic [KEY_BITS-1:0] in_word;
  logic                in_accept;

  assign in_mode   = mode_e'(s_axis_tuser);
  assign in_index  = s_axis_tdata[9:0];
  assign in_word   = s_axis_tdata[OFS_DATA +: KEY_BITS];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  logic [KEY_INDEX_W-1:0] addr_a, addr_b, addr_c;
  item_ctrl_t             in_ctrl;

  zph_addr_gen u_addr_gen (
    .mode_i           (in_mode),
    .color_i          (s_axis_tdata[OFS_COL]),
    .piece_kind_i     (s_axis_tdata[OFS_KIND +: 3]),
    .square_i         (s_axis_tdata[OFS_SQ +: 6]),
    .target_square_i  (s_axis_tdata[OFS_TSQ +: 6]),
    .promotion_kind_i (s_axis_tdata[OFS_PRO +: 3]),
    .captured_kind_i  (s_axis_tdata[OFS_CAP +: 3]),
    .castle_side_i    (s_axis_tdata[OFS_SIDE]),
    .ep_file_i        (s_axis_tdata[OFS_FILE +: 3]),
    .black_to_move_i  (s_axis_tdata[OFS_BLK]),
    .addr_a_o         (addr_a),
    .addr_b_o         (addr_b),
    .addr_c_o         (addr_c),
    .ctrl_o           (in_ctrl)
  );

  // Key table copies; every copy takes each write.
  logic                table_we;
  logic [AW-1:0]       table_waddr;
  logic [KEY_BITS-1:0] key_a, key_b, key_c;

  assign table_we    = in_accept && (in_mode == MODE_WRITE) &&
                       (32'(in_index) < KEY_TABLE_DEPTH);
  assign table_waddr = AW'(in_index);

  zph_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_TABLE_DEPTH)) u_table_a (
    .clk_i   (clk_i),
    .we_i    (table_we),
    .waddr_i (table_waddr),
    .wdata_i (in_word),
    .re_i    (in_accept),
    .raddr_i (AW'(addr_a)),
    .rdata_o (key_a)
  );

  zph_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_TABLE_DEPTH)) u_table_b (
    .clk_i   (clk_i),
    .we_i    (table_we),
    .waddr_i (table_waddr),
    .wdata_i (in_word),
    .re_i    (in_accept),
    .raddr_i (AW'(addr_b)),
    .rdata_o (key_b)
  );

  zph_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_TABLE_DEPTH)) u_table_c (
    .clk_i   (clk_i),
    .we_i    (table_we),
    .waddr_i (table_waddr),
    .wdata_i (in_word),
    .re_i    (in_accept),
    .raddr_i (AW'(addr_c)),
    .rdata_o (key_c)
  );

  // Read stage: the request waits here while its keys come out of the table.
  logic                s1_valid_q;
  item_ctrl_t          s1_ctrl_q;
  logic [KEY_BITS-1:0] s1_word_q;
  logic                s1_fire;
  logic                out_valid_q;

  // The table outputs only change on a new read, so a stalled request keeps
  // its keys as long as the input is closed.
  assign s1_fire       = s1_valid_q &&
                         (!s1_ctrl_q.has_result || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ctrl_q <= in_ctrl;
      s1_word_q <= in_word;
    end
  end

  logic                              res_kind;
  logic [NUM_KEYS-1:0][KEY_BITS-1:0] res_keys;

  zph_accum #(.KEY_BITS(KEY_BITS)) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .ctrl_i     (s1_ctrl_q),
    .word_i     (s1_word_q),
    .key_a_i    (key_a),
    .key_b_i    (key_b),
    .key_c_i    (key_c),
    .res_kind_o (res_kind),
    .res_keys_o (res_keys)
  );

  // Output register
  logic                              out_load;
  logic                              out_valid_d;
  logic                              out_kind_q;
  logic [NUM_KEYS-1:0][KEY_BITS-1:0] out_keys_q;

  assign out_load = s1_fire && s1_ctrl_q.has_result;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= res_kind;
      out_keys_q <= res_keys;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tuser[0] = out_kind_q;
  assign m_axis_tdata    = M_TDATA_W'(out_keys_q);

  // Assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ctrl_q.has_result && out_valid_q && !m_axis_tready
    |-> !s_axis_tready)
    else $error("request taken while a result is blocked in the read stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result from the read stage did not reach the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_ctrl_q))
    else $error("stalled request in the read stage was lost or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == RES_MOVE)
    |-> (out_keys_q[NUM_KEYS-1:1] == '0))
    else $error("move result carries nonzero accumulator keys");

endmodule

// File: rtl/zph_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read and read enable.
// ----------------------------------------------------------------------------
module zph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/zph_addr_gen.sv
// ----------------------------------------------------------------------------
// Key address generator
// Decodes an incoming request into up to three key table addresses and the
// control word that the key stage needs when the read data returns.
// ----------------------------------------------------------------------------
module zph_addr_gen (
  input  zph_pkg::mode_e                    mode_i,
  input  logic                              color_i,
  input  logic [2:0]                        piece_kind_i,
  input  logic [5:0]                        square_i,
  input  logic [5:0]                        target_square_i,
  input  logic [2:0]                        promotion_kind_i,
  input  logic [2:0]                        captured_kind_i,
  input  logic                              castle_side_i,
  input  logic [2:0]                        ep_file_i,
  input  logic                              black_to_move_i,
  output logic [zph_pkg::KEY_INDEX_W-1:0]   addr_a_o,
  output logic [zph_pkg::KEY_INDEX_W-1:0]   addr_b_o,
  output logic [zph_pkg::KEY_INDEX_W-1:0]   addr_c_o,
  output zph_pkg::item_ctrl_t               ctrl_o
);
  import zph_pkg::*;

  logic                   kind_ok;
  logic [2:0]             arrive_kind;
  logic [KEY_INDEX_W-1:0] idx_a;

  assign kind_ok     = (piece_kind_i <= KIND_KING);
  // A promotion code above king means the mover arrives unchanged.
  assign arrive_kind = (promotion_kind_i <= KIND_KING) ? promotion_kind_i : piece_kind_i;

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.mode       = mode_i;
    ctrl_o.color      = color_i;
    ctrl_o.kind       = piece_kind_i;
    idx_a             = piece_index(color_i, piece_kind_i, square_i);
    unique case (mode_i)
      MODE_PIECE: begin
        ctrl_o.use_a = kind_ok;
      end
      MODE_CASTLE: begin
        ctrl_o.use_a = 1'b1;
        idx_a        = CASTLE_BASE + KEY_INDEX_W'({color_i, castle_side_i});
      end
      MODE_EP: begin
        ctrl_o.use_a = 1'b1;
        idx_a        = EP_BASE + KEY_INDEX_W'(ep_file_i);
      end
      MODE_FINISH: begin
        ctrl_o.use_a      = black_to_move_i;
        ctrl_o.has_result = 1'b1;
        idx_a             = SIDE_INDEX;
      end
      MODE_MOVE: begin
        ctrl_o.use_a      = kind_ok;
        ctrl_o.use_b      = (arrive_kind <= KIND_KING);
        ctrl_o.use_c      = (captured_kind_i <= KIND_KING);
        ctrl_o.has_result = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Unused ports read entry zero so that no address runs past the table.
  assign addr_a_o = ctrl_o.use_a ? idx_a : '0;
  assign addr_b_o = ctrl_o.use_b ? piece_index(color_i, arrive_kind, target_square_i) : '0;
  assign addr_c_o = ctrl_o.use_c ? piece_index(~color_i, captured_kind_i, target_square_i) : '0;

endmodule

// File: rtl/zph_accum.sv
// ----------------------------------------------------------------------------
// Key accumulators
// Holds the seven position accumulators, folds returned keys into them and
// forms the finish and move results.
// ----------------------------------------------------------------------------
module zph_accum #(
  parameter int KEY_BITS = zph_pkg::KEY_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       fire_i,
  input  zph_pkg::item_ctrl_t                        ctrl_i,
  input  logic [KEY_BITS-1:0]                        word_i,
  input  logic [KEY_BITS-1:0]                        key_a_i,
  input  logic [KEY_BITS-1:0]                        key_b_i,
  input  logic [KEY_BITS-1:0]                        key_c_i,
  output logic                                       res_kind_o,
  output logic [zph_pkg::NUM_KEYS-1:0][KEY_BITS-1:0] res_keys_o
);
  import zph_pkg::*;

  logic [NUM_KEYS-1:0][KEY_BITS-1:0] acc_q, acc_d;
  logic [KEY_BITS-1:0]               ka, kb, kc;

  assign ka = ctrl_i.use_a ? key_a_i : '0;
  assign kb = ctrl_i.use_b ? key_b_i : '0;
  assign kc = ctrl_i.use_c ? key_c_i : '0;

  assign res_kind_o = (ctrl_i.mode == MODE_MOVE) ? RES_MOVE : RES_POSITION;

  always_comb begin
    acc_d      = acc_q;
    res_keys_o = '0;
    unique case (ctrl_i.mode)
      MODE_PIECE: begin
        acc_d[KEY_FULL] = acc_q[KEY_FULL] ^ ka;
        if (ctrl_i.kind == KIND_PAWN) begin
          acc_d[KEY_PAWN] = acc_q[KEY_PAWN] ^ ka;
        end else if (ctrl_i.color) begin
          acc_d[KEY_NPBLACK] = acc_q[KEY_NPBLACK] ^ ka;
        end else begin
          acc_d[KEY_NPWHITE] = acc_q[KEY_NPWHITE] ^ ka;
        end
        if (ctrl_i.kind == KIND_PAWN || ctrl_i.kind == KIND_KING) begin
          acc_d[KEY_KPAWN] = acc_q[KEY_KPAWN] ^ ka;
        end
        if (ctrl_i.kind == KIND_KNIGHT || ctrl_i.kind == KIND_BISHOP ||
            ctrl_i.kind == KIND_KING) begin
          acc_d[KEY_MINOR] = acc_q[KEY_MINOR] ^ ka;
        end
        if (ctrl_i.kind == KIND_ROOK || ctrl_i.kind == KIND_QUEEN ||
            ctrl_i.kind == KIND_KING) begin
          acc_d[KEY_MAJOR] = acc_q[KEY_MAJOR] ^ ka;
        end
      end
      MODE_CASTLE, MODE_EP: begin
        acc_d[KEY_FULL] = acc_q[KEY_FULL] ^ ka;
      end
      MODE_FINISH: begin
        res_keys_o           = acc_q;
        res_keys_o[KEY_FULL] = acc_q[KEY_FULL] ^ ka;
        acc_d                = '0;
      end
      MODE_MOVE: begin
        res_keys_o[KEY_FULL] = word_i ^ ka ^ kb ^ kc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (fire_i) begin
      acc_q <= acc_d;
    end
  end

endmodule
